[design/fvn_pkg.sv]
// ---------------------------------------------------------------------------
// fvn_pkg: shared types and constants of the fractal value noise block
// Field widths, register indexes, fixed-point constants, pipeline word type.
// ---------------------------------------------------------------------------
package fvn_pkg;

   // port field widths
   localparam int COORD_W    = 16;
   localparam int NOISE_W    = 16;
   localparam int OCT_W      = 4;
   localparam int AMP_W      = 16;
   localparam int FREQ_W     = 24;
   localparam int PERS_W     = 16;
   localparam int SEED_W     = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_AMPLITUDE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_FREQUENCY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED      = 3'd4;

   // coordinate times frequency (signed 16 x unsigned 24)
   localparam int PROD_W  = COORD_W + FREQ_W + 1;
   // scaled coordinate after the per-octave doubling
   localparam int SCALE_W = 64;
   // weighted sum, Q42
   localparam int ACC_W   = 52;
   // cell index and hash words
   localparam int HASH_W  = 32;
   // cosine weight, Q.16 in [0, 65536]
   localparam int WGT_W   = 17;
   // corner product and blend widths
   localparam int MIX_W   = 50;
   localparam int TERM_W  = 49;

   // fixed-point constants
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint          ONE_Q30 = 64'sd1073741824;
   localparam logic [HASH_W-1:0] HASH_MUL_ROW = 32'd57;
   localparam logic [HASH_W-1:0] HASH_MUL_SQ  = 32'd15731;
   localparam logic [HASH_W-1:0] HASH_ADD     = 32'd789221;

   // output normalisation: clamp to 2.4, divide by 2.4 as (x*5) / (3 * 2^29)
   localparam int P_W      = ACC_W + 3;
   localparam int MAG_W    = 17;
   localparam int NORM_SH  = 29;
   localparam logic [15:0] RECIP_3 = 16'd21845;

   // word moved between octave stages
   typedef struct packed {
      logic                     valid;
      logic signed [PROD_W-1:0] px;
      logic signed [PROD_W-1:0] py;
      logic signed [ACC_W-1:0]  acc;
      logic [AMP_W-1:0]         amp;
   } fvn_beat_type;

endpackage

[design/fvn_octave.sv]
// ---------------------------------------------------------------------------
// fvn_octave: one octave of value noise, eleven register stages
// Cell split and cosine weight, corner hash, bilinear blend, amplitude weight.
// ---------------------------------------------------------------------------
module fvn_octave #(
   parameter int OCT_INDEX      = 0,
   parameter int COS_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           active,
   input  logic [fvn_pkg::PERS_W-1:0]     persistence,
   input  logic [fvn_pkg::SEED_W-1:0]     hash_seed,
   input  fvn_pkg::fvn_beat_type          beat_i,
   output fvn_pkg::fvn_beat_type          beat_o
);
   import fvn_pkg::*;

   localparam int COS_N = 1 << COS_TABLE_BITS;
   localparam int K_W   = COS_TABLE_BITS + 1;

   typedef logic [15:0] cos_lut_type [0:COS_N];

   // quarter-wave cosine, Q1.15, by a Taylor series to the x^16 term in Q2.30
   function automatic cos_lut_type build_cos();
      cos_lut_type     lut;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned term;
      longint          sum;
      longint          r;
      for (int j = 0; j <= COS_N; j++) begin
         t    = (PI_Q30 * 64'(j)) >> (COS_TABLE_BITS + 1);
         t2   = (t * t) >> 30;
         term = 64'(ONE_Q30);
         sum  = ONE_Q30;
         for (int n = 1; n <= 8; n++) begin
            term = (term * t2) >> 30;
            term = term / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum <= 0) begin
            r = 0;
         end else begin
            r = longint'((64'(sum) + 64'd16384) >> 15);
            if (r > 32768) begin
               r = 32768;
            end
         end
         lut[j] = 16'(r);
      end
      return lut;
   endfunction

   localparam cos_lut_type COS_LUT = build_cos();

   // cosine weight from the fraction magnitude
   function automatic logic [WGT_W-1:0] weight_of(input logic [15:0] mag);
      logic [K_W-1:0] k;
      logic [K_W-1:0] idx;
      logic           low_half;
      k        = mag[15 -: K_W];
      low_half = (k <= K_W'(COS_N));
      idx      = low_half ? k : (~k + K_W'(1));
      if (low_half) begin
         weight_of = WGT_W'(32768) - WGT_W'(COS_LUT[idx]);
      end else begin
         weight_of = WGT_W'(32768) + WGT_W'(COS_LUT[idx]);
      end
   endfunction

   // cell index, truncated toward zero, low 32 bits
   function automatic logic [HASH_W-1:0] cell_of(input logic signed [SCALE_W-1:0] s);
      logic nudge;
      nudge   = s[SCALE_W-1] && (s[15:0] != 16'd0);
      cell_of = s[HASH_W+15:16] + HASH_W'(nudge);
   endfunction

   function automatic logic [15:0] frac_mag(input logic signed [SCALE_W-1:0] s);
      frac_mag = s[SCALE_W-1] ? (~s[15:0] + 16'd1) : s[15:0];
   endfunction

   // word delay line, stages 1 to 10
   fvn_beat_type beat_ff [1:10];
   fvn_beat_type beat_out_ff;
   fvn_beat_type beat_out_in;

   logic signed [SCALE_W-1:0] sx;
   logic signed [SCALE_W-1:0] sy;
   logic [HASH_W-1:0]         cx_in, cy_in, cx_ff, cy_ff;
   logic [WGT_W-1:0]          wx_ff [1:5];
   logic [WGT_W-1:0]          wy_ff [1:7];

   logic [HASH_W-1:0] n_in  [0:3];
   logic [HASH_W-1:0] n_ff  [0:3];
   logic [HASH_W-1:0] n2_ff [0:3];
   logic [HASH_W-1:0] n3_ff [0:3];
   logic [HASH_W-1:0] nn_ff [0:3];
   logic [HASH_W-1:0] q_ff  [0:3];
   logic [HASH_W-1:0] v_full [0:3];
   logic [SEED_W-1:0] v_ff  [0:3];
   logic signed [HASH_W-1:0] corner [0:3];

   logic signed [MIX_W-1:0]  mx_in [0:3];
   logic signed [MIX_W-1:0]  mx_ff [0:3];
   logic signed [MIX_W-1:0]  row_sum [0:1];
   logic signed [HASH_W-1:0] r_ff [0:1];
   logic signed [MIX_W-1:0]  my_in [0:1];
   logic signed [MIX_W-1:0]  my_ff [0:1];
   logic signed [MIX_W-1:0]  col_sum;
   logic signed [HASH_W-1:0] blend_ff;
   logic signed [TERM_W-1:0] term_in, term_ff;
   logic [2*AMP_W-1:0]       amp_prod;
   logic [AMP_W-1:0]         amp_in, amp_ff;
   logic                     active_ff;

   // stage 1: scale, split into cell and fraction, weights
   always_comb begin
      sx    = SCALE_W'(beat_i.px) <<< OCT_INDEX;
      sy    = SCALE_W'(beat_i.py) <<< OCT_INDEX;
      cx_in = cell_of(sx);
      cy_in = cell_of(sy);
   end

   // stage 2: corner index mix, corners ordered x0y0, x1y0, x0y1, x1y1
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic [HASH_W-1:0] hx;
         logic [HASH_W-1:0] hy;
         logic [HASH_W-1:0] h0;
         hx      = cx_ff + HASH_W'(c % 2);
         hy      = cy_ff + HASH_W'(c / 2);
         h0      = hx + hy * HASH_MUL_ROW;
         n_in[c] = (h0 << 13) ^ h0;
      end
   end

   // stage 5 hash tail; corner value is 2^30 - v
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         v_full[c] = n3_ff[c] * q_ff[c] + HASH_W'(hash_seed);
         corner[c] = $signed(HASH_W'(ONE_Q30)) - $signed({1'b0, v_ff[c]});
      end
   end

   // stage 6: x blend products
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if ((c % 2) == 0) begin
            mx_in[c] = MIX_W'(corner[c] * $signed({1'b0, WGT_W'(65536) - wx_ff[5]}));
         end else begin
            mx_in[c] = MIX_W'(corner[c] * $signed({1'b0, wx_ff[5]}));
         end
      end
   end

   // stages 7 to 9: floor shift of rows, y products, floor shift of column
   always_comb begin
      row_sum[0] = mx_ff[0] + mx_ff[1];
      row_sum[1] = mx_ff[2] + mx_ff[3];
      my_in[0]   = MIX_W'(r_ff[0] * $signed({1'b0, WGT_W'(65536) - wy_ff[7]}));
      my_in[1]   = MIX_W'(r_ff[1] * $signed({1'b0, wy_ff[7]}));
      col_sum    = my_ff[0] + my_ff[1];
   end

   // stage 10: amplitude weighting and next amplitude
   always_comb begin
      term_in  = TERM_W'(blend_ff * $signed({1'b0, beat_ff[9].amp}));
      amp_prod = beat_ff[9].amp * persistence;
      amp_in   = amp_prod[2*AMP_W-1] ? {AMP_W{1'b1}} : amp_prod[2*AMP_W-2:15];
   end

   // stage 11: accumulate
   always_comb begin
      beat_out_in     = beat_ff[10];
      beat_out_in.amp = amp_ff;
      if (active_ff) begin
         beat_out_in.acc = beat_ff[10].acc + ACC_W'(term_ff);
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (en) begin
         beat_ff[1]  <= beat_i;
         for (int k = 2; k <= 10; k++) begin
            beat_ff[k] <= beat_ff[k-1];
         end
         beat_out_ff <= beat_out_in;

         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         wx_ff[1] <= weight_of(frac_mag(sx));
         wy_ff[1] <= weight_of(frac_mag(sy));
         for (int k = 2; k <= 5; k++) begin
            wx_ff[k] <= wx_ff[k-1];
         end
         for (int k = 2; k <= 7; k++) begin
            wy_ff[k] <= wy_ff[k-1];
         end
         for (int c = 0; c < 4; c++) begin
            n_ff[c]  <= n_in[c];
            nn_ff[c] <= n_ff[c] * n_ff[c];
            n2_ff[c] <= n_ff[c];
            q_ff[c]  <= nn_ff[c] * HASH_MUL_SQ + HASH_ADD;
            n3_ff[c] <= n2_ff[c];
            v_ff[c]  <= v_full[c][SEED_W-1:0];
            mx_ff[c] <= mx_in[c];
         end
         r_ff[0]   <= row_sum[0][HASH_W+15:16];
         r_ff[1]   <= row_sum[1][HASH_W+15:16];
         my_ff[0]  <= my_in[0];
         my_ff[1]  <= my_in[1];
         blend_ff  <= col_sum[HASH_W+15:16];
         term_ff   <= term_in;
         amp_ff    <= amp_in;
         active_ff <= active;
      end
      if (reset) begin
         for (int k = 1; k <= 10; k++) begin
            beat_ff[k].valid <= 1'b0;
         end
         beat_out_ff.valid <= 1'b0;
      end
   end

   assign beat_o = beat_out_ff;

endmodule

[design/fractal_value_noise.sv]
// ---------------------------------------------------------------------------
// fractal_value_noise: fractal value noise, one coordinate pair per cycle unless stalled
// Sums up to MAX_OCTAVES cosine-blended value noise octaves, normalised Q1.15.
// ---------------------------------------------------------------------------
//  channel | ports                                  | moves
//  --------+----------------------------------------+-------------------------
//  req     | req_valid req_ready req_coord_x/_y     | one coordinate word
//  rsp     | rsp_valid rsp_ready rsp_noise_value    | one noise word
//  csr     | csr_valid csr_ready csr_index csr_data | one register write
//
//  One word enters per cycle while rsp is not stalled; the path is the front
//  multiplier, eleven stages per octave and three normalising stages.
//  Throughput is set by the fully unrolled octave chain: one word per cycle.
//  A stall on rsp freezes every stage at once; nothing is dropped or repeated.
//  Reset clears the valid bits and the configuration registers; csr is always ready.
// ---------------------------------------------------------------------------
module fractal_value_noise #(
   parameter int MAX_OCTAVES    = 8,
   parameter int COS_TABLE_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fvn_pkg::NOISE_W-1:0] rsp_noise_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fvn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fvn_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fvn_pkg::*;

   localparam logic signed [P_W-1:0] CLAMP_LIM = P_W'(12) <<< 42;

   logic               en;
   logic [OCT_W-1:0]   octave_count_ff;
   logic [AMP_W-1:0]   base_amplitude_ff;
   logic [FREQ_W-1:0]  base_frequency_ff;
   logic [PERS_W-1:0]  persistence_ff;
   logic [SEED_W-1:0]  hash_seed_ff;

   fvn_beat_type beat0_ff;
   fvn_beat_type beat_chain [0:MAX_OCTAVES];

   logic signed [P_W-1:0] acc_ext, p_raw, p_clamp;
   logic [P_W-1:0]        p_abs;
   logic                  f1_valid_ff, f1_neg_ff;
   logic [MAG_W-1:0]      f1_mag_ff;
   logic                  f2_valid_ff, f2_neg_ff;
   logic [MAG_W-1:0]      f2_mag_ff;
   logic [MAG_W+15:0]     q0_prod;
   logic [15:0]           f2_q0_ff;
   logic [MAG_W:0]        rem;
   logic [15:0]           quot;
   logic [NOISE_W-1:0]    noise_in;
   logic                  out_valid_ff;
   logic [NOISE_W-1:0]    noise_ff;

   // global advance: the output word is free or being taken
   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff   <= '0;
         base_amplitude_ff <= '0;
         base_frequency_ff <= '0;
         persistence_ff    <= '0;
         hash_seed_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OCTAVE_COUNT:   octave_count_ff   <= csr_data[OCT_W-1:0];
            CSR_BASE_AMPLITUDE: base_amplitude_ff <= csr_data[AMP_W-1:0];
            CSR_BASE_FREQUENCY: base_frequency_ff <= csr_data[FREQ_W-1:0];
            CSR_PERSISTENCE:    persistence_ff    <= csr_data[PERS_W-1:0];
            CSR_HASH_SEED:      hash_seed_ff      <= csr_data[SEED_W-1:0];
            default: ;
         endcase
      end
   end

   // front stage: coordinate times base frequency
   always_ff @(posedge clock) begin
      if (en) begin
         beat0_ff.valid <= req_valid;
         beat0_ff.px    <= PROD_W'(req_coord_x * $signed({1'b0, base_frequency_ff}));
         beat0_ff.py    <= PROD_W'(req_coord_y * $signed({1'b0, base_frequency_ff}));
         beat0_ff.acc   <= '0;
         beat0_ff.amp   <= base_amplitude_ff;
      end
      if (reset) begin
         beat0_ff.valid <= 1'b0;
      end
   end

   assign beat_chain[0] = beat0_ff;

   // octave chain; octaves past the count add nothing
   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
      logic active;
      assign active = (octave_count_ff > OCT_W'(i));
      fvn_octave #(
         .OCT_INDEX      (i),
         .COS_TABLE_BITS (COS_TABLE_BITS)
      ) u_octave (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .active      (active),
         .persistence (persistence_ff),
         .hash_seed   (hash_seed_ff),
         .beat_i      (beat_chain[i]),
         .beat_o      (beat_chain[i+1])
      );
   end

   // normalise 1: times five, clamp, magnitude over 2^29
   always_comb begin
      acc_ext = P_W'(beat_chain[MAX_OCTAVES].acc);
      p_raw   = (acc_ext <<< 2) + acc_ext;
      if (p_raw > CLAMP_LIM) begin
         p_clamp = CLAMP_LIM;
      end else if (p_raw < -CLAMP_LIM) begin
         p_clamp = -CLAMP_LIM;
      end else begin
         p_clamp = p_raw;
      end
      p_abs = p_clamp[P_W-1] ? P_W'(-p_clamp) : p_clamp;
   end

   // normalise 2: divide by three through the reciprocal, low estimate
   assign q0_prod = f1_mag_ff * RECIP_3;

   // normalise 3: one correction step, sign, saturate at plus one
   always_comb begin
      rem  = (MAG_W+1)'(f2_mag_ff) - (MAG_W+1)'(f2_q0_ff) * (MAG_W+1)'(3);
      quot = f2_q0_ff + 16'(rem >= (MAG_W+1)'(3));
      if (f2_neg_ff) begin
         noise_in = NOISE_W'(~quot + 16'd1);
      end else if (quot[15]) begin
         noise_in = {1'b0, {(NOISE_W-1){1'b1}}};
      end else begin
         noise_in = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_valid_ff  <= beat_chain[MAX_OCTAVES].valid;
         f1_neg_ff    <= p_clamp[P_W-1];
         f1_mag_ff    <= p_abs[NORM_SH+MAG_W-1:NORM_SH];
         f2_valid_ff  <= f1_valid_ff;
         f2_neg_ff    <= f1_neg_ff;
         f2_mag_ff    <= f1_mag_ff;
         f2_q0_ff     <= q0_prod[31:16];
         out_valid_ff <= f2_valid_ff;
         noise_ff     <= noise_in;
      end
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_noise_value = $signed(noise_ff);

   // checks
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(f1_valid_ff) && $stable(f2_valid_ff))
      else $error("pipeline moved during a stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> beat0_ff.valid)
      else $error("accepted word missing from front stage");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("not ready while output empty");

   a_div_correct: assert property (@(posedge clock) disable iff (reset)
      f2_valid_ff |-> rem < (MAG_W+1)'(6))
      else $error("reciprocal estimate off by more than one");

endmodule

[verif/fvn_noise_checker.sv]
// ---------------------------------------------------------------------------
// fvn_noise_checker: predicts and checks every noise word of the block
// Tracks register writes, computes the expected noise for each accepted
// coordinate word and compares it with the words leaving the rsp channel.
// ---------------------------------------------------------------------------
module fvn_noise_checker #(
   parameter int MAX_OCTAVES    = 8,
   parameter int COS_TABLE_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [fvn_pkg::COORD_W-1:0] req_coord_y,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [fvn_pkg::NOISE_W-1:0] rsp_noise_value,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [fvn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fvn_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                 fail_count,
   output int                                 pending
);
   import fvn_pkg::*;

   localparam int TAB_N = 1 << COS_TABLE_BITS;

   longint cos_tab [0:TAB_N];

   logic [OCT_W-1:0]  octaves;
   logic [AMP_W-1:0]  base_amp;
   logic [FREQ_W-1:0] base_freq;
   logic [PERS_W-1:0] persist;
   logic [SEED_W-1:0] seed;

   logic signed [NOISE_W-1:0] expected_noise [$];

   // quarter-wave cosine in Q1.15, Taylor series in Q2.30
   function automatic longint cos_q15(int j);
      longint unsigned t, t2, term;
      longint sum, r;
      t    = (PI_Q30 * longint'(j)) >> (COS_TABLE_BITS + 1);
      t2   = (t * t) >> 30;
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int n = 1; n <= 8; n++) begin
         term = (term * t2) >> 30;
         term = term / longint'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum <= 0) return 0;
      r = longint'(($unsigned(sum) + 16384) >> 15);
      return (r > 32768) ? 32768 : r;
   endfunction

   initial begin
      for (int j = 0; j <= TAB_N; j++) cos_tab[j] = cos_q15(j);
   end

   function automatic longint interp_weight(longint frac);
      longint mag, k;
      mag = (frac < 0 ? -frac : frac) & 64'hFFFF;
      k   = mag >> (15 - COS_TABLE_BITS);
      if (k <= TAB_N) return 32768 - cos_tab[k];
      return 32768 + cos_tab[2 * TAB_N - k];
   endfunction

   function automatic longint corner_value(logic [31:0] cx, logic [31:0] cy);
      logic [31:0] n, v;
      n = cx + cy * HASH_MUL_ROW;
      n = (n << 13) ^ n;
      v = (n * (n * n * HASH_MUL_SQ + HASH_ADD) + {1'b0, seed}) & 32'h7fffffff;
      return ONE_Q30 - longint'({32'd0, v});
   endfunction

   // floor shift of the blend comes from the arithmetic shift
   function automatic longint mix(longint a, longint b, longint w);
      return (a * (65536 - w) + b * w) >>> 16;
   endfunction

   function automatic longint octave_blend(longint sx, longint sy);
      longint ix, iy, fx, fy, wx, wy, r0, r1;
      logic [31:0] cx, cy;
      ix = sx / 65536;
      iy = sy / 65536;
      fx = sx - ix * 65536;
      fy = sy - iy * 65536;
      cx = ix[31:0];
      cy = iy[31:0];
      wx = interp_weight(fx);
      wy = interp_weight(fy);
      r0 = mix(corner_value(cx, cy), corner_value(cx + 1, cy), wx);
      r1 = mix(corner_value(cx, cy + 1), corner_value(cx + 1, cy + 1), wx);
      return mix(r0, r1, wy);
   endfunction

   function automatic logic signed [NOISE_W-1:0] predict_noise(
      logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      longint cnt, amp, sum, f, p, r;
      cnt = (octaves > MAX_OCTAVES) ? MAX_OCTAVES : octaves;
      amp = base_amp;
      sum = 0;
      for (int i = 0; i < cnt; i++) begin
         f   = longint'(base_freq) << i;
         sum = sum + octave_blend(longint'(x) * f, longint'(y) * f) * amp;
         amp = (amp * longint'(persist)) >> 15;
         if (amp > 65535) amp = 65535;
      end
      // clamp to +-2.4 then normalise
      p = sum * 5;
      if (p > (longint'(12) << 42)) p = longint'(12) << 42;
      if (p < -(longint'(12) << 42)) p = -(longint'(12) << 42);
      r = p / 64'sd1610612736;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[NOISE_W-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   initial fail_count = 0;

   // register shadow, expectations and comparison
   always @(posedge clock) begin
      if (reset) begin
         octaves   <= '0;
         base_amp  <= '0;
         base_freq <= '0;
         persist   <= '0;
         seed      <= '0;
         expected_noise.delete();
         pending   <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OCTAVE_COUNT: begin
                  octaves <= csr_data[OCT_W-1:0];
               end
               CSR_BASE_AMPLITUDE: begin
                  base_amp <= csr_data[AMP_W-1:0];
               end
               CSR_BASE_FREQUENCY: begin
                  base_freq <= csr_data[FREQ_W-1:0];
               end
               CSR_PERSISTENCE: begin
                  persist <= csr_data[PERS_W-1:0];
               end
               CSR_HASH_SEED: begin
                  seed <= csr_data[SEED_W-1:0];
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_noise.push_back(predict_noise(req_coord_x, req_coord_y));
         if (rsp_valid && rsp_ready) begin
            if (expected_noise.size() == 0) begin
               report_mismatch($sformatf("unexpected noise word %0d", rsp_noise_value));
            end else begin
               if (rsp_noise_value !== expected_noise[0])
                  report_mismatch($sformatf("noise_value %0d, expected %0d",
                                            rsp_noise_value, expected_noise[0]));
               void'(expected_noise.pop_front());
            end
         end
         pending <= expected_noise.size();
      end
   end

endmodule

[verif/fractal_value_noise_tb.sv]
// ---------------------------------------------------------------------------
// fractal_value_noise_tb: stimulus and verdict for the fractal noise block
// Runs phases of register settings with directed and random coordinates
// under varying idle and stall patterns; a checker predicts every word.
// ---------------------------------------------------------------------------
module fractal_value_noise_tb;
   import fvn_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 120;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [NOISE_W-1:0] rsp_noise_value;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   fractal_value_noise DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_coord_x, .req_coord_y,
      .rsp_valid, .rsp_ready, .rsp_noise_value,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   fvn_noise_checker checker_i (
      .clock, .reset,
      .req_valid, .req_ready, .req_coord_x, .req_coord_y,
      .rsp_valid, .rsp_ready, .rsp_noise_value,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // valid stays up between back-to-back words
   task automatic send_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender pauses until all words are back, then the pipeline drains
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int oct, int amp, int freq, int pers, int sd);
      settle();
      csr_write(CSR_OCTAVE_COUNT, oct);
      csr_write(CSR_BASE_AMPLITUDE, amp);
      csr_write(CSR_BASE_FREQUENCY, freq);
      csr_write(CSR_PERSISTENCE, pers);
      csr_write(CSR_HASH_SEED, sd);
   endtask

   task automatic random_coords(int count);
      logic [COORD_W-1:0] x, y;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            x = COORD_W'($urandom_range(64) - 32);
            y = COORD_W'($urandom_range(64) - 32);
         end else begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
         end
         send_coord(x, y);
      end
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
         default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
   endtask

   initial begin
      int freq;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero octaves after reset
      send_coord(16'h7fff, 16'h8000);
      send_coord(16'h0000, 16'hffff);

      // directed extremes, amplitude growth and full scale
      configure(8, 65535, 24'hffffff, 65535, 31'h7fffffff);
      send_coord(16'h7fff, 16'h7fff);
      send_coord(16'h8000, 16'h8000);
      send_coord(16'h8000, 16'h7fff);
      send_coord(16'h0000, 16'h0000);
      send_coord(16'hffff, 16'h0001);
      configure(15, 4096, 24'h010000, 16384, 0);
      send_coord(16'h0001, 16'hffff);
      send_coord(16'h1234, 16'hedcb);
      send_coord(16'h8000, 16'h0000);
      configure(1, 4096, 24'h008000, 0, 12345);
      send_coord(16'hffff, 16'hffff);
      send_coord(16'h0001, 16'h0003);
      send_coord(16'hfffd, 16'h0005);
      configure(3, 40000, 24'h00c000, 32768, 999);
      send_coord(16'h0003, 16'hfffb);
      send_coord(16'h7fff, 16'h8001);

      // unknown register indexes must not disturb the settings
      settle();
      csr_write(3'd5, 32'hffffffff);
      csr_write(3'd6, 32'h0);
      csr_write(3'd7, 32'h5a5a5a5a);
      send_coord(16'h0002, 16'h0007);

      // random settings under rotating idle patterns
      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(2))
            0: freq = $urandom_range(24'h020000);
            1: freq = $urandom_range(24'h0400);
            default: freq = $urandom & 24'hffffff;
         endcase
         configure($urandom_range(15), $urandom & 16'hffff, freq,
                   $urandom & 16'hffff, $urandom & 32'h7fffffff);
         set_idling(ph);
         random_coords(50);
      end

      settle();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
